// ===== design/gprm_pkg.sv =====
// Package for the grid push-relabel max-flow block: word types, register
// indexes, reset values, controller states and the command and status structs.
// Depends on nothing.
package gprm_pkg;

    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_BASE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_SHIFT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OP_LIMIT   = 8'd3;

    localparam logic [7:0]  EDGE_BASE_RST = 8'd63;
    localparam logic [7:0]  SINK_BASE_RST = 8'd255;
    localparam logic [2:0]  PIX_SHIFT_RST = 3'd2;
    localparam logic [15:0] OP_LIMIT_RST  = 16'hFFFF;

    localparam int               HEIGHT_W     = 16;
    localparam logic [HEIGHT_W-1:0] HEIGHT_SAT = 16'hFFFF;
    localparam int               FLOW_W       = 14;
    localparam logic [FLOW_W-1:0] FLOW_OUT_SAT = 14'd16383;

    typedef struct packed {
        logic [7:0] intensity;
        logic [7:0] source_weight;
        logic       last_node;
    } t_in_word;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic              converged;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_CAP,
        S_INIT_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NB_RD,
        S_NB_CAP,
        S_EXEC,
        S_TGT_RD,
        S_TGT_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_INIT,
        ADDR_NB_K,
        ADDR_NB_TGT
    } t_addr_sel;

    typedef struct packed {
        logic      ld_we;
        logic      ptr_clr;
        logic      ptr_inc;
        logic      k_clr;
        logic      k_inc;
        logic      tot_clr;
        logic      init_cap;
        logic      init_wr;
        logic      conv_cap;
        logic      cur_cap;
        logic      op_inc;
        logic      nh_cap;
        logic      exec;
        logic      tgt_wr;
        logic      out_load;
        t_addr_sel addr_sel;
    } t_cmd;

    typedef struct packed {
        logic k_init_done;
        logic k_nb_done;
        logic ptr_last;
        logic found;
        logic limit_hit;
        logic push_nb;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/gprm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gprm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gprm_ctrl.sv =====
// Sequencer for the max-flow block: load, preflow, scan, push/relabel, result.
// Depends on gprm_pkg.
module gprm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  gprm_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output gprm_pkg::t_cmd o_cmd
);

    gprm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gprm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gprm_pkg::S_IDLE: begin
                if (i_in_valid && i_in_last) n_state = gprm_pkg::S_INIT_RD;
            end
            gprm_pkg::S_INIT_RD:  n_state = gprm_pkg::S_INIT_CAP;
            gprm_pkg::S_INIT_CAP: begin
                n_state = i_sts.k_init_done ? gprm_pkg::S_INIT_WR : gprm_pkg::S_INIT_RD;
            end
            gprm_pkg::S_INIT_WR: begin
                n_state = i_sts.ptr_last ? gprm_pkg::S_SCAN_RD : gprm_pkg::S_INIT_RD;
            end
            gprm_pkg::S_SCAN_RD:  n_state = gprm_pkg::S_SCAN_CHK;
            gprm_pkg::S_SCAN_CHK: begin
                if (i_sts.found) begin
                    n_state = i_sts.limit_hit ? gprm_pkg::S_DONE : gprm_pkg::S_NB_RD;
                end else begin
                    n_state = i_sts.ptr_last ? gprm_pkg::S_DONE : gprm_pkg::S_SCAN_RD;
                end
            end
            gprm_pkg::S_NB_RD:  n_state = gprm_pkg::S_NB_CAP;
            gprm_pkg::S_NB_CAP: begin
                n_state = i_sts.k_nb_done ? gprm_pkg::S_EXEC : gprm_pkg::S_NB_RD;
            end
            gprm_pkg::S_EXEC: begin
                n_state = i_sts.push_nb ? gprm_pkg::S_TGT_RD : gprm_pkg::S_SCAN_RD;
            end
            gprm_pkg::S_TGT_RD: n_state = gprm_pkg::S_TGT_WR;
            gprm_pkg::S_TGT_WR: n_state = gprm_pkg::S_SCAN_RD;
            gprm_pkg::S_DONE: begin
                if (!i_sts.out_busy) n_state = gprm_pkg::S_IDLE;
            end
            default: n_state = gprm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.addr_sel = gprm_pkg::ADDR_PTR;
        o_in_ready = 1'b0;
        case (r_state)
            gprm_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.ld_we = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                    o_cmd.tot_clr = 1'b1;
                end
            end
            gprm_pkg::S_INIT_RD: o_cmd.addr_sel = gprm_pkg::ADDR_INIT;
            gprm_pkg::S_INIT_CAP: begin
                o_cmd.init_cap = 1'b1;
                o_cmd.k_inc    = 1'b1;
            end
            gprm_pkg::S_INIT_WR: begin
                o_cmd.init_wr = 1'b1;
                o_cmd.k_clr   = 1'b1;
                o_cmd.ptr_clr = i_sts.ptr_last;
                o_cmd.ptr_inc = !i_sts.ptr_last;
            end
            gprm_pkg::S_SCAN_RD: o_cmd.addr_sel = gprm_pkg::ADDR_PTR;
            gprm_pkg::S_SCAN_CHK: begin
                o_cmd.conv_cap = 1'b1;
                if (i_sts.found) begin
                    o_cmd.cur_cap = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                    o_cmd.op_inc  = !i_sts.limit_hit;
                end else begin
                    o_cmd.ptr_inc = !i_sts.ptr_last;
                end
            end
            gprm_pkg::S_NB_RD: o_cmd.addr_sel = gprm_pkg::ADDR_NB_K;
            gprm_pkg::S_NB_CAP: begin
                o_cmd.nh_cap = 1'b1;
                o_cmd.k_inc  = 1'b1;
            end
            gprm_pkg::S_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.ptr_clr = !i_sts.push_nb;
            end
            gprm_pkg::S_TGT_RD: o_cmd.addr_sel = gprm_pkg::ADDR_NB_TGT;
            gprm_pkg::S_TGT_WR: begin
                o_cmd.addr_sel = gprm_pkg::ADDR_NB_TGT;
                o_cmd.tgt_wr   = 1'b1;
                o_cmd.ptr_clr  = 1'b1;
            end
            gprm_pkg::S_DONE: o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/gprm_dp.sv =====
// Datapath of the max-flow block: configuration registers, load and node
// memories, node pointer, push/relabel logic and the result register.
// Depends on gprm_pkg and gprm_ram.
module gprm_dp #(
    parameter int GRID_ROWS = gprm_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gprm_pkg::GRID_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [gprm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gprm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  gprm_pkg::t_in_word                i_in_data,
    input  gprm_pkg::t_cmd                    i_cmd,
    input  logic                              i_out_ready,
    output gprm_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output gprm_pkg::t_out_word               o_out_data
);

    localparam int N      = GRID_ROWS * GRID_COLS;
    localparam int NW     = $clog2(N);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int HW     = gprm_pkg::HEIGHT_W;
    localparam int EXC_W  = 8 + NW;
    localparam int SUM_W  = (EXC_W > gprm_pkg::FLOW_W) ? EXC_W : gprm_pkg::FLOW_W;
    localparam int NODE_W = 40 + 32 + HW + EXC_W + 8;
    localparam logic [HW-1:0] TOP_HEIGHT = HW'(N + 3);

    logic [7:0]  r_edge_base, r_sink_base;
    logic [2:0]  r_shift;
    logic [15:0] r_limit;

    logic [NW-1:0] r_load, r_ptr;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [2:0]    r_k;
    logic [15:0]   r_ops;
    logic [SUM_W-1:0] r_sink;
    logic          r_conv;
    logic          r_out_valid;
    gprm_pkg::t_out_word r_out;

    logic [4:0][7:0]    r_room;
    logic [3:0][7:0]    r_res;
    logic [HW-1:0]      r_hgt;
    logic [EXC_W-1:0]   r_exc;
    logic [7:0]         r_sret;
    logic [7:0]         r_pa, r_sw;
    logic [HW-1:0]      r_nh [4];
    logic [1:0]         r_tgt;
    logic [7:0]         r_f;
    logic               r_fwd;

    logic [NW-1:0]  nb_addr [4];
    logic [3:0]     nb_ex;
    logic [1:0]     init_dir;
    logic [NW-1:0]  rd_addr, node_waddr;
    logic [15:0]    ld_rdata;
    logic [NODE_W-1:0] node_rdata, node_wdata;
    logic           node_we;

    logic [4:0][7:0]  u_room;
    logic [3:0][7:0]  u_res;
    logic [HW-1:0]    u_hgt;
    logic [EXC_W-1:0] u_exc;
    logic [7:0]       u_sret;

    logic [7:0] pb, diff, edge_cap, sink_cap;

    logic [3:0]       open_f, open_r, low;
    logic [4:0][7:0]  x_room;
    logic [3:0][7:0]  x_res;
    logic [HW-1:0]    x_hgt;
    logic [EXC_W-1:0] x_exc;
    logic [7:0]       x_sret, x_f, x_sink;
    logic [1:0]       x_tgt;
    logic             x_fwd, x_go_nb;

    logic [3:0][7:0]  res_upd;
    logic [1:0]       opp;

    function automatic logic [7:0] take_min(input logic [EXC_W-1:0] e, input logic [7:0] v);
        take_min = (e < EXC_W'(v)) ? e[7:0] : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_base <= gprm_pkg::EDGE_BASE_RST;
            r_sink_base <= gprm_pkg::SINK_BASE_RST;
            r_shift     <= gprm_pkg::PIX_SHIFT_RST;
            r_limit     <= gprm_pkg::OP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gprm_pkg::REG_EDGE_BASE: r_edge_base <= i_cfg_data[7:0];
                gprm_pkg::REG_SINK_BASE: r_sink_base <= i_cfg_data[7:0];
                gprm_pkg::REG_PIX_SHIFT: r_shift     <= i_cfg_data[2:0];
                gprm_pkg::REG_OP_LIMIT:  r_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        nb_addr[0] = r_ptr - NW'(GRID_COLS);
        nb_addr[1] = r_ptr + NW'(1);
        nb_addr[2] = r_ptr + NW'(GRID_COLS);
        nb_addr[3] = r_ptr - NW'(1);
        nb_ex[0]   = (r_row != '0);
        nb_ex[1]   = (r_col != CW'(GRID_COLS - 1));
        nb_ex[2]   = (r_row != RW'(GRID_ROWS - 1));
        nb_ex[3]   = (r_col != '0);
    end

    assign init_dir = 2'(r_k - 3'd1);

    always_comb begin
        case (i_cmd.addr_sel)
            gprm_pkg::ADDR_PTR:    rd_addr = r_ptr;
            gprm_pkg::ADDR_INIT:   rd_addr = (r_k == 3'd0) ? r_ptr : nb_addr[init_dir];
            gprm_pkg::ADDR_NB_K:   rd_addr = nb_addr[r_k[1:0]];
            gprm_pkg::ADDR_NB_TGT: rd_addr = nb_addr[r_tgt];
            default:               rd_addr = r_ptr;
        endcase
    end

    gprm_ram #(.WIDTH(16), .DEPTH(N)) u_ld_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_we),
        .i_waddr (r_load),
        .i_wdata ({i_in_data.intensity, i_in_data.source_weight}),
        .i_raddr (rd_addr),
        .o_rdata (ld_rdata)
    );

    assign node_we    = i_cmd.init_wr || i_cmd.exec || i_cmd.tgt_wr;
    assign node_waddr = i_cmd.tgt_wr ? nb_addr[r_tgt] : r_ptr;

    gprm_ram #(.WIDTH(NODE_W), .DEPTH(N)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (rd_addr),
        .o_rdata (node_rdata)
    );

    assign {u_sret, u_exc, u_hgt, u_res, u_room} = node_rdata;

    assign pb       = ld_rdata[15:8] >> r_shift;
    assign diff     = (r_pa > pb) ? (r_pa - pb) : (pb - r_pa);
    assign edge_cap = (r_edge_base > diff) ? (r_edge_base - diff) : 8'd0;
    assign sink_cap = (r_sink_base > r_sw) ? (r_sink_base - r_sw) : 8'd0;

    assign opp = r_tgt + 2'd2;
    always_comb begin
        res_upd = u_res;
        if (r_fwd) res_upd[opp] = u_res[opp] + r_f;
    end

    always_comb begin
        node_wdata = {x_sret, x_exc, x_hgt, x_res, x_room};
        if (i_cmd.init_wr) begin
            node_wdata = {r_sw, EXC_W'(r_sw), HW'(0), 32'd0, sink_cap, r_room[3:0]};
        end else if (i_cmd.tgt_wr) begin
            node_wdata = {u_sret, u_exc + EXC_W'(r_f), u_hgt, res_upd, u_room};
        end
    end

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            open_f[d] = nb_ex[d] && (r_room[d] != 8'd0);
            open_r[d] = nb_ex[d] && (r_res[d] != 8'd0);
            low[d]    = r_hgt > r_nh[d];
        end
    end

    always_comb begin
        logic            hit, pushed;
        logic [3:0]      sel;
        logic [HW-1:0]   m;
        x_room = r_room;
        x_res  = r_res;
        x_hgt  = r_hgt;
        x_exc  = r_exc;
        x_sret = r_sret;
        x_f    = 8'd0;
        x_sink = 8'd0;
        x_tgt  = 2'd0;
        x_fwd  = 1'b0;
        x_go_nb = 1'b0;
        hit    = 1'b0;
        pushed = 1'b0;
        sel    = 4'd0;
        m      = gprm_pkg::HEIGHT_SAT;
        if (r_room[4] != 8'd0) begin
            x_f       = take_min(r_exc, r_room[4]);
            x_room[4] = r_room[4] - x_f;
            x_exc     = r_exc - EXC_W'(x_f);
            x_sink    = x_f;
            pushed    = 1'b1;
        end else begin
            for (int d = 0; d < 4; d++) begin
                if (!hit && open_f[d] && low[d]) begin
                    hit   = 1'b1;
                    x_tgt = 2'(d);
                end
            end
            if (hit) begin
                x_f           = take_min(r_exc, r_room[x_tgt]);
                x_room[x_tgt] = r_room[x_tgt] - x_f;
                x_exc         = r_exc - EXC_W'(x_f);
                x_fwd         = 1'b1;
                x_go_nb       = 1'b1;
                pushed        = 1'b1;
            end else if (open_f == 4'd0) begin
                for (int d = 0; d < 4; d++) begin
                    if (!hit && open_r[d] && low[d]) begin
                        hit   = 1'b1;
                        x_tgt = 2'(d);
                    end
                end
                if (hit) begin
                    x_f          = take_min(r_exc, r_res[x_tgt]);
                    x_res[x_tgt] = r_res[x_tgt] - x_f;
                    x_exc        = r_exc - EXC_W'(x_f);
                    x_go_nb      = 1'b1;
                    pushed       = 1'b1;
                end else if (open_r == 4'd0) begin
                    x_f    = take_min(r_exc, r_sret);
                    x_sret = r_sret - x_f;
                    x_exc  = r_exc - EXC_W'(x_f);
                    pushed = (x_f != 8'd0);
                end
            end
        end
        if (!pushed) begin
            sel = (open_f != 4'd0) ? open_f : open_r;
            if (r_room[4] != 8'd0) begin
                x_hgt = '0;
            end else if (sel == 4'd0) begin
                x_hgt = TOP_HEIGHT;
            end else begin
                for (int d = 0; d < 4; d++) begin
                    if (sel[d] && (r_nh[d] < m)) m = r_nh[d];
                end
                x_hgt = (m == gprm_pkg::HEIGHT_SAT) ? gprm_pkg::HEIGHT_SAT : m + HW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load      <= '0;
            r_ptr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_ops       <= '0;
            r_sink      <= '0;
            r_conv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_we) begin
                if (i_in_data.last_node || r_load == NW'(N - 1)) r_load <= '0;
                else r_load <= r_load + NW'(1);
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + NW'(1);
                if (r_col == CW'(GRID_COLS - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.k_clr) r_k <= '0;
            else if (i_cmd.k_inc) r_k <= r_k + 3'd1;
            if (i_cmd.tot_clr) begin
                r_ops  <= '0;
                r_sink <= '0;
            end else begin
                if (i_cmd.op_inc) r_ops <= r_ops + 16'd1;
                if (i_cmd.exec) r_sink <= r_sink + SUM_W'(x_sink);
            end
            if (i_cmd.conv_cap) r_conv <= !o_sts.found;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_cap) begin
            if (r_k == 3'd0) begin
                r_pa <= ld_rdata[15:8] >> r_shift;
                r_sw <= ld_rdata[7:0];
            end else begin
                r_room[init_dir] <= nb_ex[init_dir] ? edge_cap : 8'd0;
            end
        end
        if (i_cmd.cur_cap) begin
            r_room <= u_room;
            r_res  <= u_res;
            r_hgt  <= u_hgt;
            r_exc  <= u_exc;
            r_sret <= u_sret;
        end
        if (i_cmd.nh_cap) r_nh[r_k[1:0]] <= u_hgt;
        if (i_cmd.exec) begin
            r_tgt <= x_tgt;
            r_f   <= x_f;
            r_fwd <= x_fwd;
        end
        if (i_cmd.out_load) begin
            r_out.max_flow  <= (r_sink > SUM_W'(gprm_pkg::FLOW_OUT_SAT)) ?
                               gprm_pkg::FLOW_OUT_SAT : r_sink[gprm_pkg::FLOW_W-1:0];
            r_out.converged <= r_conv;
        end
    end

    assign o_sts.k_init_done = (r_k == 3'd4);
    assign o_sts.k_nb_done   = (r_k == 3'd3);
    assign o_sts.ptr_last    = (r_ptr == NW'(N - 1));
    assign o_sts.found       = (u_exc != '0);
    assign o_sts.limit_hit   = (r_ops >= r_limit);
    assign o_sts.push_nb     = x_go_nb;
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/grid_push_relabel_maxflow.sv =====
// Top level of the grid push-relabel max-flow block.
// Depends on gprm_pkg, gprm_ctrl, gprm_dp and gprm_ram.
//
// Grid nodes are loaded in raster order, one word per cycle. The word that
// carries last_node starts a solve, during which no input is taken. The
// preflow reads the load memory five times per node (the node and its four
// neighbours) and then writes the node once. Each push or relabel step then
// scans from the first node up to the first overflowing one, reads the four
// neighbour heights, updates the node and, when flow moves to a neighbour,
// reads and writes that neighbour; every read goes through the single read
// port of the node memory. One result word follows each solve.
module grid_push_relabel_maxflow #(
    parameter int GRID_ROWS = gprm_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gprm_pkg::GRID_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gprm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gprm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gprm_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gprm_pkg::t_out_word             o_out_data
);

    gprm_pkg::t_cmd cmd;
    gprm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    gprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_node),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gprm_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.last_node) |=> !o_in_ready)
        else $error("Input still taken after the last node.");

    a_result_after_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("Result appeared without a solve.");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ld_we && (cmd.init_wr || cmd.exec || cmd.tgt_wr)))
        else $error("Load and node memory written together.");

endmodule
